FILE: hdl/cpl_pkg.sv
package cpl_pkg;

   localparam int LEN_LAT   = 36;  // magnitude stages plus one root bit per stage
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 32;
   localparam int CSR_IDX_W = 8;

   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P  = 8'd0,
      CSR_GAIN_D  = 8'd1,
      CSR_STRETCH = 8'd2,
      CSR_FORCE   = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] target_pos_x;
      logic signed [31:0] target_pos_y;
      logic signed [31:0] target_pos_z;
      logic signed [31:0] target_vel_x;
      logic signed [31:0] target_vel_y;
      logic signed [31:0] target_vel_z;
      logic signed [31:0] body_pos_x;
      logic signed [31:0] body_pos_y;
      logic signed [31:0] body_pos_z;
      logic signed [31:0] body_vel_x;
      logic signed [31:0] body_vel_y;
      logic signed [31:0] body_vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               stretched;
      logic               force_clamped;
   } rsp_type;

   typedef logic [2:0][51:0] mag3_type;

   // vector length result: shift, root of shifted sum, shifted magnitudes
   typedef struct packed {
      logic [4:0]       shift;
      logic [31:0]      len;
      logic [2:0][30:0] part;
   } len_type;

   function automatic logic [32:0] mag33(input logic [32:0] v);
      return v[32] ? (~v + 33'd1) : v;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [51:0] mag52(input logic [51:0] v);
      return v[51] ? (~v + 52'd1) : v;
   endfunction

endpackage

FILE: hdl/pd_coupling_force_limiter.sv
// PD coupling force with stretch limit and force clamp. One beat per cycle
// is accepted while the pipeline flows; every beat gives one result beat
// once it has passed the pipeline and the output buffer. The depth is
// set by the two vector-length units (a 32-stage square root, one root bit
// per stage) and the two banks of 32-stage restoring dividers (one quotient
// bit per stage) used to shrink the error and the force. A two-entry output
// buffer lets new beats in while a finished result waits; the whole pipeline
// holds only when both entries are full. Configuration writes are taken in
// every cycle (csr_ready is always high) and must only be issued while idle.
module pd_coupling_force_limiter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cpl_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cpl_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import cpl_pkg::*;

   localparam int DEPTH = 1 + LEN_LAT + 1 + DIV_STEPS + 4 + LEN_LAT + 1 + DIV_STEPS;

   typedef struct packed {
      logic [2:0][32:0] err;
      logic [2:0][31:0] tv;
      logic [2:0][31:0] bv;
   } st0_type;

   typedef struct packed {
      logic [2:0][32:0] err;
      logic [2:0][31:0] tv;
      logic [2:0][31:0] bv;
      logic [2:0][61:0] prod;
      logic [2:0][63:0] nvprod;
      logic [33:0]      reach;
      logic [31:0]      len;
      logic             stretched;
   } stc_type;

   typedef struct packed {
      logic [2:0][32:0] err;
      logic [2:0][31:0] tv;
      logic [2:0][31:0] bv;
      logic [2:0][28:0] nvq;
      logic             stretched;
   } sb2_type;

   typedef struct packed {
      logic [2:0][32:0] err;
      logic [2:0][32:0] ve;
      logic [2:0][31:0] nv;
      logic [32:0]      kd;
      logic [31:0]      slip2;
      logic             stretched;
   } std_type;

   typedef struct packed {
      logic [2:0][32:0] err;
      logic [2:0][32:0] ve;
      logic [2:0][31:0] nv;
      logic [32:0]      kd;
      logic [31:0]      kp;
      logic             stretched;
   } ste_type;

   typedef struct packed {
      logic [2:0][48:0] pm;
      logic [2:0]       psign;
      logic [2:0][49:0] dm;
      logic [2:0]       dsign;
      logic [2:0][31:0] nv;
      logic             stretched;
   } stf_type;

   typedef struct packed {
      logic [2:0][51:0] f;
      logic [2:0][31:0] nv;
      logic             stretched;
   } stg_type;

   typedef struct packed {
      logic [2:0][51:0] f;
      logic [2:0][31:0] nv;
      logic [2:0][61:0] prod;
      logic [31:0]      len;
      logic             stretched;
      logic             clamped;
   } sth_type;

   typedef struct packed {
      logic [2:0][51:0] f;
      logic [2:0][31:0] nv;
      logic             stretched;
      logic             clamped;
   } sb4_type;

   // configuration
   logic [31:0] gain_p_ff, gain_d_ff;
   logic [30:0] stretch_ff, force_ff;

   logic             en;
   logic [DEPTH-1:0] vld_ff;

   logic [2:0][31:0] tp, tv, bp, bv;
   st0_type  st0_ff, st0_in;
   st0_type  d1_ff [LEN_LAT];
   mag3_type mag1, mag2;
   len_type  len1, len2;
   stc_type  stc_ff, stc_in;
   sb2_type  d2_ff [DIV_STEPS];
   sb2_type  sb2_in;
   std_type  std_ff, std_in;
   ste_type  ste_ff, ste_in;
   stf_type  stf_ff, stf_in;
   stg_type  stg_ff, stg_in;
   stg_type  d3_ff [LEN_LAT];
   sth_type  sth_ff, sth_in;
   sb4_type  d4_ff [DIV_STEPS];
   sb4_type  sb4_in;

   logic [31:0]      qe [3];
   logic [31:0]      qf [3];
   logic [31:0]      slip;
   logic [63:0]      slsq;
   logic [63:0]      kpp;
   logic [64:0]      pprod [3];
   logic [65:0]      dprod [3];
   logic [52:0]      flen;
   logic [2:0][51:0] ffin;
   logic [2:0][31:0] fsat;
   rsp_type          push_data;
   logic             push;

   // output buffer
   logic    rsp_valid_ff, skd_valid_ff;
   rsp_type rsp_data_ff, skd_data_ff;
   logic    pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= 32'd65536;
         gain_d_ff  <= 32'd0;
         stretch_ff <= 31'd65536;
         force_ff   <= 31'h7FFF_FFFF;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_GAIN_P:  gain_p_ff  <= csr_data;
            CSR_GAIN_D:  gain_d_ff  <= csr_data;
            CSR_STRETCH: stretch_ff <= csr_data[30:0];
            CSR_FORCE:   force_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // hold the whole pipeline only while both buffer entries are taken
   assign en        = !skd_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // stage 0: position error
   always_comb begin
      tp = {req_data.target_pos_z, req_data.target_pos_y, req_data.target_pos_x};
      tv = {req_data.target_vel_z, req_data.target_vel_y, req_data.target_vel_x};
      bp = {req_data.body_pos_z, req_data.body_pos_y, req_data.body_pos_x};
      bv = {req_data.body_vel_z, req_data.body_vel_y, req_data.body_vel_x};
      for (int i = 0; i < 3; i++) begin
         st0_in.err[i] = {tp[i][31], tp[i]} - {bp[i][31], bp[i]};
      end
      st0_in.tv = tv;
      st0_in.bv = bv;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1[i] = {19'd0, mag33(st0_ff.err[i])};
      end
   end

   cpl_len3 u_len_err (
      .clock   (clock),
      .en      (en),
      .mag_in  (mag1),
      .len_out (len1)
   );

   // stage C: stretch test, shrink dividends, divide-by-ten product
   always_comb begin
      stc_in.err  = d1_ff[LEN_LAT-1].err;
      stc_in.tv   = d1_ff[LEN_LAT-1].tv;
      stc_in.bv   = d1_ff[LEN_LAT-1].bv;
      stc_in.len  = len1.len;
      // error magnitude is below 2^33, so the shift never exceeds two
      stc_in.reach = {2'b00, len1.len} << len1.shift[1:0];
      stc_in.stretched = stc_in.reach > {3'b000, stretch_ff};
      for (int i = 0; i < 3; i++) begin
         stc_in.prod[i]   = len1.part[i] * stretch_ff;
         stc_in.nvprod[i] = mag32(d1_ff[LEN_LAT-1].bv[i]) * DIV10_RECIP;
      end
   end

   always_comb begin
      sb2_in.err       = stc_ff.err;
      sb2_in.tv        = stc_ff.tv;
      sb2_in.bv        = stc_ff.bv;
      sb2_in.stretched = stc_ff.stretched;
      for (int i = 0; i < 3; i++) begin
         sb2_in.nvq[i] = stc_ff.nvprod[i][63:35];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div_err
      cpl_div u_div (
         .clock (clock),
         .en    (en),
         .num   ({2'b00, stc_ff.prod[g]}),
         .den   ({2'b00, stc_ff.len}),
         .quo   (qe[g])
      );
   end

   cpl_div u_div_slip (
      .clock (clock),
      .en    (en),
      .num   ({1'b0, stretch_ff, 32'd0}),
      .den   (stc_ff.reach),
      .quo   (slip)
   );

   // stage D: apply the stretch, damp the velocity, square the slip ratio
   always_comb begin
      std_in.stretched = d2_ff[DIV_STEPS-1].stretched;
      for (int i = 0; i < 3; i++) begin
         if (std_in.stretched) begin
            std_in.err[i] = d2_ff[DIV_STEPS-1].err[i][32] ? (~{1'b0, qe[i]} + 33'd1)
                                                          : {1'b0, qe[i]};
            std_in.nv[i]  = d2_ff[DIV_STEPS-1].bv[i][31]
                          ? (~{3'b000, d2_ff[DIV_STEPS-1].nvq[i]} + 32'd1)
                          : {3'b000, d2_ff[DIV_STEPS-1].nvq[i]};
         end else begin
            std_in.err[i] = d2_ff[DIV_STEPS-1].err[i];
            std_in.nv[i]  = d2_ff[DIV_STEPS-1].bv[i];
         end
         std_in.ve[i] = {d2_ff[DIV_STEPS-1].tv[i][31], d2_ff[DIV_STEPS-1].tv[i]}
                      - {std_in.nv[i][31], std_in.nv[i]};
      end
      std_in.kd    = std_in.stretched ? {gain_d_ff, 1'b0} : {1'b0, gain_d_ff};
      slsq         = slip * slip;
      std_in.slip2 = slsq[63:32];
   end

   // stage E: scale the proportional gain
   always_comb begin
      kpp              = gain_p_ff * std_ff.slip2;
      ste_in.err       = std_ff.err;
      ste_in.ve        = std_ff.ve;
      ste_in.nv        = std_ff.nv;
      ste_in.kd        = std_ff.kd;
      ste_in.stretched = std_ff.stretched;
      ste_in.kp        = std_ff.stretched ? kpp[63:32] : gain_p_ff;
   end

   // stage F: P and D products on magnitudes
   always_comb begin
      stf_in.nv        = ste_ff.nv;
      stf_in.stretched = ste_ff.stretched;
      for (int i = 0; i < 3; i++) begin
         pprod[i]        = mag33(ste_ff.err[i]) * ste_ff.kp;
         dprod[i]        = mag33(ste_ff.ve[i]) * ste_ff.kd;
         stf_in.pm[i]    = pprod[i][64:16];
         stf_in.dm[i]    = dprod[i][65:16];
         stf_in.psign[i] = ste_ff.err[i][32];
         stf_in.dsign[i] = ste_ff.ve[i][32];
      end
   end

   // stage G: force sum
   always_comb begin
      stg_in.nv        = stf_ff.nv;
      stg_in.stretched = stf_ff.stretched;
      for (int i = 0; i < 3; i++) begin
         stg_in.f[i] = (stf_ff.psign[i] ? (~{3'b000, stf_ff.pm[i]} + 52'd1)
                                        : {3'b000, stf_ff.pm[i]})
                     + (stf_ff.dsign[i] ? (~{2'b00, stf_ff.dm[i]} + 52'd1)
                                        : {2'b00, stf_ff.dm[i]});
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag2[i] = mag52(stg_ff.f[i]);
      end
   end

   cpl_len3 u_len_force (
      .clock   (clock),
      .en      (en),
      .mag_in  (mag2),
      .len_out (len2)
   );

   // stage H: force clamp test and shrink dividends
   always_comb begin
      sth_in.f         = d3_ff[LEN_LAT-1].f;
      sth_in.nv        = d3_ff[LEN_LAT-1].nv;
      sth_in.stretched = d3_ff[LEN_LAT-1].stretched;
      sth_in.len       = len2.len;
      flen             = {21'd0, len2.len} << len2.shift;
      sth_in.clamped   = flen > {22'd0, force_ff};
      for (int i = 0; i < 3; i++) begin
         sth_in.prod[i] = len2.part[i] * force_ff;
      end
   end

   assign sb4_in = '{f: sth_ff.f, nv: sth_ff.nv, stretched: sth_ff.stretched,
                     clamped: sth_ff.clamped};

   for (genvar g = 0; g < 3; g++) begin : g_div_force
      cpl_div u_div (
         .clock (clock),
         .en    (en),
         .num   ({2'b00, sth_ff.prod[g]}),
         .den   ({2'b00, sth_ff.len}),
         .quo   (qf[g])
      );
   end

   // final: apply the clamp and saturate to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (d4_ff[DIV_STEPS-1].clamped) begin
            ffin[i] = d4_ff[DIV_STEPS-1].f[i][51] ? (~{20'd0, qf[i]} + 52'd1)
                                                  : {20'd0, qf[i]};
         end else begin
            ffin[i] = d4_ff[DIV_STEPS-1].f[i];
         end
         if (!ffin[i][51] && (|ffin[i][50:31])) begin
            fsat[i] = SAT_POS;
         end else if (ffin[i][51] && !(&ffin[i][50:31])) begin
            fsat[i] = SAT_NEG;
         end else begin
            fsat[i] = ffin[i][31:0];
         end
      end
      push_data.force_x       = fsat[0];
      push_data.force_y       = fsat[1];
      push_data.force_z       = fsat[2];
      push_data.new_vel_x     = d4_ff[DIV_STEPS-1].nv[0];
      push_data.new_vel_y     = d4_ff[DIV_STEPS-1].nv[1];
      push_data.new_vel_z     = d4_ff[DIV_STEPS-1].nv[2];
      push_data.stretched     = d4_ff[DIV_STEPS-1].stretched;
      push_data.force_clamped = d4_ff[DIV_STEPS-1].clamped;
   end

   // advance every stage and side line together
   always_ff @(posedge clock) begin
      if (en) begin
         st0_ff   <= st0_in;
         d1_ff[0] <= st0_ff;
         for (int k = 1; k < LEN_LAT; k++) d1_ff[k] <= d1_ff[k-1];
         stc_ff   <= stc_in;
         d2_ff[0] <= sb2_in;
         for (int k = 1; k < DIV_STEPS; k++) d2_ff[k] <= d2_ff[k-1];
         std_ff   <= std_in;
         ste_ff   <= ste_in;
         stf_ff   <= stf_in;
         stg_ff   <= stg_in;
         d3_ff[0] <= stg_ff;
         for (int k = 1; k < LEN_LAT; k++) d3_ff[k] <= d3_ff[k-1];
         sth_ff   <= sth_in;
         d4_ff[0] <= sb4_in;
         for (int k = 1; k < DIV_STEPS; k++) d4_ff[k] <= d4_ff[k-1];
      end
   end

   assign push = vld_ff[DEPTH-1] && en;
   assign pop  = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skd_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         // drain the skid entry first, else take the fresh beat
         rsp_valid_ff <= skd_valid_ff || push;
         skd_valid_ff <= 1'b0;
      end else if (push) begin
         skd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         rsp_data_ff <= skd_valid_ff ? skd_data_ff : push_data;
      end else if (push) begin
         skd_data_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/cpl_len3.sv
module cpl_len3 (
   input  logic              clock,
   input  logic              en,
   input  cpl_pkg::mag3_type mag_in,
   output cpl_pkg::len_type  len_out
);
   import cpl_pkg::*;

   typedef struct packed {
      logic [4:0]       shift;
      logic [2:0][30:0] part;
   } side_type;

   logic [2:0][51:0] m1_ff;
   logic [4:0]       s1_ff, s1_in;
   logic [51:0]      or_all;
   side_type         sd2_ff, sd2_in;
   side_type         sd3_ff, sd4_ff;
   logic [2:0][61:0] sq3_ff, sq3_in;
   logic [63:0]      sum4_ff, sum4_in;
   logic [63:0]      x_ff [SQRT_STEPS];
   logic [63:0]      r_ff [SQRT_STEPS];
   logic [63:0]      x_in [SQRT_STEPS];
   logic [63:0]      r_in [SQRT_STEPS];
   logic [63:0]      xi   [SQRT_STEPS];
   logic [63:0]      ri   [SQRT_STEPS];
   logic [63:0]      bitv [SQRT_STEPS];
   logic [64:0]      trial [SQRT_STEPS];
   side_type         sdq_ff [SQRT_STEPS];

   // smallest shift that brings every magnitude below 2^31
   always_comb begin
      or_all = mag_in[0] | mag_in[1] | mag_in[2];
      s1_in  = 5'd0;
      for (int i = 31; i < 52; i++) begin
         if (or_all[i]) s1_in = 5'(i - 30);
      end
   end

   always_comb begin
      sd2_in.shift = s1_ff;
      for (int i = 0; i < 3; i++) begin
         sd2_in.part[i] = 31'(m1_ff[i] >> s1_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq3_in[i] = sd2_ff.part[i] * sd2_ff.part[i];
      end
      sum4_in = 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
   end

   // one root bit per stage
   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         xi[k]    = (k == 0) ? sum4_ff : x_ff[(k == 0) ? 0 : k - 1];
         ri[k]    = (k == 0) ? 64'd0   : r_ff[(k == 0) ? 0 : k - 1];
         bitv[k]  = 64'd1 << (62 - 2 * k);
         trial[k] = {1'b0, ri[k]} + {1'b0, bitv[k]};
         if ({1'b0, xi[k]} >= trial[k]) begin
            x_in[k] = xi[k] - trial[k][63:0];
            r_in[k] = (ri[k] >> 1) + bitv[k];
         end else begin
            x_in[k] = xi[k];
            r_in[k] = ri[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= mag_in;
         s1_ff   <= s1_in;
         sd2_ff  <= sd2_in;
         sd3_ff  <= sd2_ff;
         sq3_ff  <= sq3_in;
         sd4_ff  <= sd3_ff;
         sum4_ff <= sum4_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            x_ff[k] <= x_in[k];
            r_ff[k] <= r_in[k];
            sdq_ff[k] <= (k == 0) ? sd4_ff : sdq_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign len_out.shift = sdq_ff[SQRT_STEPS-1].shift;
   assign len_out.part  = sdq_ff[SQRT_STEPS-1].part;
   assign len_out.len   = r_ff[SQRT_STEPS-1][31:0];

endmodule

FILE: hdl/cpl_div.sv
module cpl_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [33:0] den,
   output logic [31:0] quo
);
   import cpl_pkg::*;

   logic [33:0] rem_ff [DIV_STEPS];
   logic [31:0] low_ff [DIV_STEPS];
   logic [31:0] q_ff   [DIV_STEPS];
   logic [33:0] den_ff [DIV_STEPS];
   logic [33:0] rem_in [DIV_STEPS];
   logic [31:0] low_in [DIV_STEPS];
   logic [31:0] q_in   [DIV_STEPS];
   logic [33:0] ri     [DIV_STEPS];
   logic [31:0] li     [DIV_STEPS];
   logic [31:0] qi     [DIV_STEPS];
   logic [33:0] di     [DIV_STEPS];
   logic [34:0] t      [DIV_STEPS];

   // restoring division, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         ri[k] = (k == 0) ? {2'b00, num[63:32]} : rem_ff[(k == 0) ? 0 : k - 1];
         li[k] = (k == 0) ? num[31:0]           : low_ff[(k == 0) ? 0 : k - 1];
         qi[k] = (k == 0) ? 32'd0               : q_ff[(k == 0) ? 0 : k - 1];
         di[k] = (k == 0) ? den                 : den_ff[(k == 0) ? 0 : k - 1];
         t[k]  = {ri[k], li[k][31]};
         low_in[k] = {li[k][30:0], 1'b0};
         if (t[k] >= {1'b0, di[k]}) begin
            rem_in[k] = 34'(t[k] - {1'b0, di[k]});
            q_in[k]   = {qi[k][30:0], 1'b1};
         end else begin
            rem_in[k] = t[k][33:0];
            q_in[k]   = {qi[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= di[k];
         end
      end
   end

   assign quo = q_ff[DIV_STEPS-1];

endmodule
